/* sv/ain_pkg.sv */
// Shared types and constants for the adaptive instance normalisation core.
package ain_pkg;

    localparam int CHANNELS  = 512;
    localparam int CH_W      = 9;
    localparam int WALK_W    = 10;
    localparam int SUM_W     = 32;
    localparam int SQ_W      = 46;
    localparam int SCALE_W   = 24;
    localparam int SHIFT_W   = 32;
    localparam int COUNT_W   = 17;
    localparam int COUNT_CAP = 65536;
    localparam int STAT_W    = 2 * (SUM_W + SQ_W);
    localparam int PAR_W     = SCALE_W + SHIFT_W;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 8'd1;

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_STYLE   = 3'd1,
        OP_CONTENT = 3'd2,
        OP_FINAL   = 3'd3,
        OP_APPLY   = 3'd4
    } t_op;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_CLR,
        ST_SMP_RD, ST_SMP_WR,
        ST_APP_RD, ST_APP_M1, ST_APP_M2, ST_APP_OUT,
        ST_FIN_RD, ST_FIN_M0, ST_FIN_M1, ST_FIN_M2, ST_FIN_M3,
        ST_FIN_DMS, ST_FIN_DMW, ST_FIN_DVS, ST_FIN_DVW,
        ST_FIN_SQS, ST_FIN_SQW, ST_FIN_SCS, ST_FIN_SCW,
        ST_FIN_SH1, ST_FIN_SH2, ST_DONE
    } t_state;

endpackage

/* sv/ain_div.sv */
// Restoring divider, one quotient bit per cycle.
module ain_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);
    logic [64:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_dsr;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem[63:0], r_quo[63]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_trial - {1'b0, r_dsr}) : w_trial;
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

/* sv/ain_sqrt.sv */
// Integer square root, one root bit per cycle.
module ain_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_rad;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [35:0] w_cur;
    logic [35:0] w_trial;
    logic        w_ge;

    assign w_cur   = {r_rem[33:0], r_rad[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = w_cur >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= w_ge ? (w_cur - w_trial) : w_cur;
            r_root <= {r_root[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

/* sv/adaptive_instance_norm_core.sv */
// Top level of the adaptive instance normalisation core.
// One transaction at a time: busy is high from acceptance until the result strobe.
// A sample is a read-modify-write of the statistics memory, an apply a parameter
// memory read and two multiply stages; clear walks the channels and unused codes
// just finish. Finalize runs per channel through the shared 64-bit divider and
// 32-step square root. After reset the statistics memory is cleared in one pass
// with busy high. Results cannot be stalled: o_done marks them for exactly one
// cycle. Configuration writes are always taken.
module adaptive_instance_norm_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [2:0]                         i_operation,
    input  logic [ain_pkg::CH_W-1:0]           i_channel,
    input  logic signed [15:0]                 i_sample,
    output logic                               o_done,
    output logic signed [23:0]                 o_result_value,
    output logic                               o_value_valid,
    output logic                               o_saturated,
    output logic                               o_stats_ready,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ain_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ain_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import ain_pkg::*;

    t_state r_state, n_state;

    logic [8:0]          r_strength;
    logic [WALK_W-1:0]   r_cu;
    logic [WALK_W-1:0]   r_ch;
    logic [COUNT_W-1:0]  r_scount, r_ccount;
    logic                r_ready;
    logic                r_side;
    logic signed [15:0]  r_x;

    logic [STAT_W-1:0]   r_stat_mem [0:CHANNELS-1];
    logic [STAT_W-1:0]   r_stat_rd;
    logic [PAR_W-1:0]    r_par_mem [0:CHANNELS-1];
    logic [PAR_W-1:0]    r_par_rd;

    logic [63:0]         r_nsq, r_s2, r_num, r_den, r_var;
    logic signed [31:0]  r_smean, r_cmean;
    logic [31:0]         r_ssd, r_csd;
    logic [SCALE_W-1:0]  r_sc;
    logic signed [56:0]  r_prod;
    logic signed [41:0]  r_t;
    logic signed [51:0]  r_mix;

    logic                r_done, r_vvalid, r_sat;
    logic signed [23:0]  r_result;

    logic                stat_re, stat_we, par_re, par_we;
    logic [STAT_W-1:0]   stat_wd;
    logic [PAR_W-1:0]    par_wd;
    logic                div_start, sq_start, div_done, sq_done;
    logic [63:0]         div_a, div_b, div_q;
    logic [31:0]         sq_root;

    logic [WALK_W-1:0]   w_walk;
    logic                w_last;
    logic [COUNT_W-1:0]  w_n;
    logic signed [31:0]  w_sum;
    logic [SQ_W-1:0]     w_sq;
    logic [31:0]         w_mag;
    logic                w_nz;
    logic signed [32:0]  w_sum_add;
    logic [SQ_W:0]       w_sq_add;
    logic [31:0]         w_sum_new;
    logic [SQ_W-1:0]     w_sq_new;
    logic [8:0]          w_alpha;
    logic [9:0]          w_beta;
    logic [56:0]         w_pmag;
    logic [41:0]         w_pq;
    logic signed [43:0]  w_diff;
    logic [31:0]         w_shift;
    logic [51:0]         w_mmag;
    logic [28:0]         w_mq;

    assign w_walk = (r_cu > WALK_W'(CHANNELS)) ? WALK_W'(CHANNELS) : r_cu;
    assign w_last = (r_ch + WALK_W'(1)) == w_walk;
    assign w_n    = r_side ? r_ccount : r_scount;
    assign w_nz   = w_n != '0;
    assign w_sum  = r_side ? $signed(r_stat_rd[SQ_W+SUM_W+SUM_W-1:SQ_W+SUM_W])
                           : $signed(r_stat_rd[SUM_W-1:0]);
    assign w_sq   = r_side ? r_stat_rd[STAT_W-1:SQ_W+2*SUM_W]
                           : r_stat_rd[SQ_W+SUM_W-1:SUM_W];
    assign w_mag  = w_sum[31] ? 32'(-w_sum) : 32'(w_sum);

    assign w_sum_add = 33'(w_sum) + 33'(r_x);
    assign w_sq_add  = {1'b0, w_sq} + (SQ_W+1)'(32'(r_x * r_x));
    assign w_sum_new = (w_sum_add > 33'sh0_7FFF_FFFF) ? 32'h7FFF_FFFF :
                       (w_sum_add < -33'sh0_8000_0000) ? 32'h8000_0000 : w_sum_add[31:0];
    assign w_sq_new  = w_sq_add[SQ_W] ? {SQ_W{1'b1}} : w_sq_add[SQ_W-1:0];

    assign w_alpha = (r_strength > 9'd256) ? 9'd256 : r_strength;
    assign w_beta  = 10'd256 - {1'b0, w_alpha};

    assign w_pmag  = r_prod[56] ? 57'(-r_prod) : 57'(r_prod);
    assign w_pq    = 42'((w_pmag + 57'd32768) >> 16);
    assign w_diff  = 44'(r_smean) - (r_prod[56] ? -$signed({2'b00, w_pq})
                                                :  $signed({2'b00, w_pq}));
    assign w_shift = (w_diff > 44'sh7FFF_FFFF) ? 32'h7FFF_FFFF :
                     (w_diff < -44'sh8000_0000) ? 32'h8000_0000 : w_diff[31:0];

    assign w_mmag  = r_mix[51] ? 52'(-r_mix) : 52'(r_mix);
    assign w_mq    = 29'((w_mmag + 52'h80_0000) >> 24);

    always_ff @(posedge i_clk) begin
        if (stat_we) r_stat_mem[r_ch[CH_W-1:0]] <= stat_wd;
        if (stat_re) r_stat_rd <= r_stat_mem[r_ch[CH_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (par_we) r_par_mem[r_ch[CH_W-1:0]] <= par_wd;
        if (par_re) r_par_rd <= r_par_mem[r_ch[CH_W-1:0]];
    end

    ain_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    ain_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (64'((r_var + 64'd1) << 16)),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT:    if (r_ch == WALK_W'(CHANNELS - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_operation)
                        OP_CLEAR:   n_state = (w_walk == '0) ? ST_DONE : ST_CLR;
                        OP_STYLE,
                        OP_CONTENT: n_state = ST_SMP_RD;
                        OP_FINAL:   n_state = (w_walk == '0) ? ST_DONE : ST_FIN_RD;
                        OP_APPLY:   n_state = ST_APP_RD;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLR:     if (w_last) n_state = ST_DONE;
            ST_SMP_RD:  n_state = ST_SMP_WR;
            ST_SMP_WR:  n_state = ST_IDLE;
            ST_APP_RD:  n_state = ST_APP_M1;
            ST_APP_M1:  n_state = ST_APP_M2;
            ST_APP_M2:  n_state = ST_APP_OUT;
            ST_APP_OUT: n_state = ST_IDLE;
            ST_FIN_RD:  n_state = ST_FIN_M0;
            ST_FIN_M0:  n_state = ST_FIN_M1;
            ST_FIN_M1:  n_state = ST_FIN_M2;
            ST_FIN_M2:  n_state = ST_FIN_M3;
            ST_FIN_M3:  n_state = ST_FIN_DMS;
            ST_FIN_DMS: n_state = w_nz ? ST_FIN_DMW : ST_FIN_DVS;
            ST_FIN_DMW: if (div_done) n_state = ST_FIN_DVS;
            ST_FIN_DVS: n_state = w_nz ? ST_FIN_DVW : ST_FIN_SQS;
            ST_FIN_DVW: if (div_done) n_state = ST_FIN_SQS;
            ST_FIN_SQS: n_state = ST_FIN_SQW;
            ST_FIN_SQW: if (sq_done) n_state = r_side ? ST_FIN_SCS : ST_FIN_M0;
            ST_FIN_SCS: n_state = ST_FIN_SCW;
            ST_FIN_SCW: if (div_done) n_state = ST_FIN_SH1;
            ST_FIN_SH1: n_state = ST_FIN_SH2;
            ST_FIN_SH2: n_state = w_last ? ST_DONE : ST_FIN_RD;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        stat_re   = 1'b0;
        stat_we   = 1'b0;
        stat_wd   = '0;
        par_re    = 1'b0;
        par_we    = 1'b0;
        par_wd    = {w_shift, r_sc};
        div_start = 1'b0;
        sq_start  = 1'b0;
        div_a     = '0;
        div_b     = '0;
        unique case (r_state)
            ST_INIT, ST_CLR: stat_we = 1'b1;
            ST_SMP_RD, ST_FIN_RD: stat_re = 1'b1;
            ST_SMP_WR: begin
                stat_we = 1'b1;
                stat_wd = r_stat_rd;
                if (r_side) stat_wd[STAT_W-1:SQ_W+SUM_W] = {w_sq_new, w_sum_new};
                else        stat_wd[SQ_W+SUM_W-1:0]      = {w_sq_new, w_sum_new};
            end
            ST_APP_RD: par_re = 1'b1;
            ST_FIN_DMS: begin
                div_start = w_nz;
                div_a     = 64'({w_mag, 8'd0}) + 64'(w_n >> 1);
                div_b     = 64'(w_n);
            end
            ST_FIN_DVS: begin
                div_start = w_nz;
                div_a     = r_num;
                div_b     = r_den;
            end
            ST_FIN_SQS: sq_start = 1'b1;
            ST_FIN_SCS: begin
                div_start = 1'b1;
                div_a     = 64'({r_ssd, 16'd0}) + 64'(r_csd >> 1);
                div_b     = 64'(r_csd);
            end
            ST_FIN_SH2: par_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_ch       <= '0;
            r_strength <= 9'd256;
            r_cu       <= 10'd512;
            r_scount   <= '0;
            r_ccount   <= '0;
            r_ready    <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_STRENGTH) r_strength <= i_cfg_data[8:0];
                else if (i_cfg_index == CFG_CHANNELS) r_cu <= i_cfg_data[WALK_W-1:0];
            end
            unique case (r_state)
                ST_INIT: r_ch <= r_ch + WALK_W'(1);
                ST_IDLE: begin
                    r_ch <= (i_operation == OP_CLEAR || i_operation == OP_FINAL)
                            ? '0 : WALK_W'(i_channel);
                    if (i_start) begin
                        if (i_operation == OP_CLEAR) begin
                            r_scount <= '0;
                            r_ccount <= '0;
                            r_ready  <= 1'b0;
                        end else if (i_operation == OP_FINAL) begin
                            r_ready <= 1'b1;
                        end else if (i_operation == OP_STYLE && i_channel == '0
                                     && r_scount < COUNT_W'(COUNT_CAP)) begin
                            r_scount <= r_scount + COUNT_W'(1);
                        end else if (i_operation == OP_CONTENT && i_channel == '0
                                     && r_ccount < COUNT_W'(COUNT_CAP)) begin
                            r_ccount <= r_ccount + COUNT_W'(1);
                        end
                    end
                end
                ST_CLR:     r_ch <= r_ch + WALK_W'(1);
                ST_FIN_SH2: r_ch <= r_ch + WALK_W'(1);
                ST_SMP_WR, ST_APP_OUT, ST_DONE: r_done <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_x      <= i_sample;
                r_side   <= (i_operation == OP_CONTENT);
                r_result <= '0;
                r_vvalid <= 1'b0;
                r_sat    <= 1'b0;
            end
            ST_APP_M1: r_t <= $signed(r_x) * $signed({1'b0, r_par_rd[SCALE_W-1:0]})
                            + ($signed(r_par_rd[PAR_W-1:SCALE_W]) <<< 8);
            ST_APP_M2: r_mix <= $signed({1'b0, w_alpha}) * r_t
                              + $signed({1'b0, w_beta}) * ($signed(r_x) <<< 16);
            ST_APP_OUT: begin
                r_vvalid <= 1'b1;
                if (!r_mix[51] && w_mq > 29'd8388607) begin
                    r_result <= 24'sh7F_FFFF;
                    r_sat    <= 1'b1;
                end else if (r_mix[51] && w_mq > 29'd8388608) begin
                    r_result <= -24'sh80_0000;
                    r_sat    <= 1'b1;
                end else begin
                    r_result <= r_mix[51] ? -$signed(w_mq[23:0]) : $signed(w_mq[23:0]);
                end
            end
            ST_FIN_RD: r_side <= 1'b0;
            ST_FIN_M0: r_nsq <= 64'(w_n * w_sq[22:0]);
            ST_FIN_M1: r_nsq <= r_nsq + (64'(w_n * w_sq[SQ_W-1:23]) << 23);
            ST_FIN_M2: r_s2 <= 64'(w_mag * w_mag);
            ST_FIN_M3: begin
                r_den <= 64'(w_n * ((w_n > COUNT_W'(1)) ? (w_n - COUNT_W'(1)) : COUNT_W'(1)));
                r_num <= (r_s2 >= r_nsq) ? 64'd0 : (r_nsq - r_s2);
            end
            ST_FIN_DMS: begin
                if (!w_nz) begin
                    if (r_side) r_cmean <= '0;
                    else        r_smean <= '0;
                end
            end
            ST_FIN_DMW: begin
                if (div_done) begin
                    if (r_side) r_cmean <= w_sum[31]
                        ? ((div_q > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(div_q[31:0]))
                        : ((div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(div_q[31:0]));
                    else        r_smean <= w_sum[31]
                        ? ((div_q > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(div_q[31:0]))
                        : ((div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(div_q[31:0]));
                end
            end
            ST_FIN_DVS: if (!w_nz) r_var <= 64'(w_sq);
            ST_FIN_DVW: if (div_done) r_var <= div_q;
            ST_FIN_SQW: begin
                if (sq_done) begin
                    if (r_side) r_csd <= sq_root;
                    else        r_ssd <= sq_root;
                    r_side <= 1'b1;
                end
            end
            ST_FIN_SCW: if (div_done)
                r_sc <= (div_q > 64'hFF_FFFF) ? {SCALE_W{1'b1}} : div_q[SCALE_W-1:0];
            ST_FIN_SH1: r_prod <= r_cmean * $signed({1'b0, r_sc});
            ST_DONE: begin
                r_result <= '0;
                r_vvalid <= 1'b0;
                r_sat    <= 1'b0;
            end
            default: ;
        endcase
    end

    assign o_busy         = r_state != ST_IDLE;
    assign o_done         = r_done;
    assign o_result_value = r_result;
    assign o_value_valid  = r_vvalid;
    assign o_saturated    = r_sat;
    assign o_stats_ready  = r_ready;
    assign o_cfg_ready    = 1'b1;
endmodule
